### rtl/rcfp_pkg.sv
`default_nettype none
package rcfp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int DIST_W    = 31;
   localparam int FACE_W    = 3;
   localparam int NUM_FACES = 6;
   localparam int NUM_AXES  = 3;
   // magnitude of c +- half - o
   localparam int NUM_W     = COORD_W + 1;
   localparam int DIV_W     = COORD_W;
   localparam int REM_W     = NUM_W + FRAC_BITS;
   localparam int CMP_W     = DIV_W + DIST_W;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int OFF_W     = 2 * COORD_W - FRAC_BITS + 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MAX_LEN = 1'b0;

   localparam longint MAX_LEN_RAW = longint'(1000) <<< FRAC_BITS;
   localparam longint MAX_LEN_CAP = (longint'(1) <<< DIST_W) - 1;
   localparam logic [DIST_W-1:0] MAX_LEN_RESET =
      DIST_W'((MAX_LEN_RAW > MAX_LEN_CAP) ? MAX_LEN_CAP : MAX_LEN_RAW);

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [COORD_W-1:0] dir_x;
      logic signed [COORD_W-1:0] dir_y;
      logic signed [COORD_W-1:0] dir_z;
      logic signed [COORD_W-1:0] centre_x;
      logic signed [COORD_W-1:0] centre_y;
      logic signed [COORD_W-1:0] centre_z;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic [FACE_W-1:0]         face;
      logic signed [COORD_W-1:0] neighbour_x;
      logic signed [COORD_W-1:0] neighbour_y;
      logic signed [COORD_W-1:0] neighbour_z;
      logic [DIST_W-1:0]         distance;
   } rsp_type;

   // one slot of the divider chain: six long divisions in flight
   typedef struct packed {
      req_type                             ray;
      logic [NUM_FACES-1:0]                cand;
      logic [NUM_FACES-1:0][REM_W-1:0]     rem;
      logic [NUM_FACES-1:0][DIST_W-1:0]    quo;
      logic [NUM_AXES-1:0][DIV_W-1:0]      dvs;
   } div_type;

   typedef struct packed {
      req_type                             ray;
      logic [NUM_FACES-1:0]                ok;
      logic [NUM_FACES-1:0][DIST_W-1:0]    t;
      logic [NUM_FACES-1:0][1:0][PROD_W-1:0] prod;
   } mul_type;

   function automatic logic signed [COORD_W-1:0] pick3(
      input logic signed [COORD_W-1:0] vx,
      input logic signed [COORD_W-1:0] vy,
      input logic signed [COORD_W-1:0] vz,
      input logic [1:0]                ax);
      logic signed [COORD_W-1:0] r;
      unique case (ax)
         2'd1:    r = vy;
         2'd2:    r = vz;
         default: r = vx;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/ray_cube_face_pick_unit.sv
`default_nettype none
// Pipeline: the item passes 34 registers
// (one setup stage, 31 divider cells, one multiply stage, and the output register
// behind the compare-and-select logic), the first loading at the accepting edge.
// Throughput: one item per cycle unless rsp_ready holds off the output; the 31-cell
// divider chain retires one quotient bit per cell, so every stage holds a different item.
// Reset: synchronous, clears all stage valid bits and loads max_len_ff with 1000.0.
module ray_cube_face_pick_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire rcfp_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output rcfp_pkg::rsp_type                        rsp_data,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [rcfp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [rcfp_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rcfp_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                     pready
);
   import rcfp_pkg::*;

   localparam int CELLS = DIST_W;

   // Configuration: one register at byte address 0; paddr[2] picks the register.
   logic [DIST_W-1:0] max_len_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_LEN)) begin
         max_len_ff <= pwdata[DIST_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_MAX_LEN) begin
         prdata = CSR_DATA_W'(max_len_ff);
      end
   end

   // Stage 0 is the setup stage, stages 1..CELLS are the divider cells.
   // Each stage loads when it is empty or its successor loads too.
   logic [CELLS:0]    vld;
   div_type           stg [CELLS+1];
   logic [CELLS+1:0]  load;
   logic              pick_ready;

   always_comb begin
      load[CELLS+1] = pick_ready;
      for (int j = CELLS; j >= 0; j--) begin
         load[j] = !vld[j] || load[j+1];
      end
   end
   assign req_ready = load[0];

   rcfp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .load     (load[0]),
      .in_valid (req_valid),
      .in_data  (req_data),
      .valid_ff (vld[0]),
      .data_ff  (stg[0])
   );

   // Cell j settles quotient bit CELLS-j, most significant bit first.
   for (genvar j = 1; j <= CELLS; j++) begin : g_cell
      rcfp_div_cell #(
         .BIT (CELLS - j)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .load     (load[j]),
         .in_valid (vld[j-1]),
         .in_data  (stg[j-1]),
         .valid_ff (vld[j]),
         .data_ff  (stg[j])
      );
   end

   // Multiply, check the hit square, pick the nearest face, hold the result.
   rcfp_pick u_pick (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld[CELLS]),
      .in_data   (stg[CELLS]),
      .max_len   (max_len_ff),
      .in_ready  (pick_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### rtl/rcfp_front.sv
`default_nettype none
module rcfp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire logic              in_valid,
   input  wire rcfp_pkg::req_type in_data,
   output logic                   valid_ff,
   output rcfp_pkg::div_type      data_ff
);
   import rcfp_pkg::*;

   localparam logic signed [NUM_W:0] HALF_N = (NUM_W+1)'(1) <<< (FRAC_BITS - 1);

   div_type data_in;

   always_comb begin
      logic signed [COORD_W-1:0] oa, ca, da;
      logic signed [NUM_W:0]     num;
      logic [NUM_W-1:0]          nabs;
      logic [DIV_W-1:0]          dabs;
      logic [CMP_W-1:0]          nsh;
      logic                      den_neg, ovf, cnd;
      data_in = '0;
      data_in.ray = in_data;
      for (int i = 0; i < NUM_FACES; i++) begin
         oa = pick3(in_data.origin_x, in_data.origin_y, in_data.origin_z, 2'(i / 2));
         ca = pick3(in_data.centre_x, in_data.centre_y, in_data.centre_z, 2'(i / 2));
         da = pick3(in_data.dir_x, in_data.dir_y, in_data.dir_z, 2'(i / 2));
         if (i % 2 == 0) begin
            num     = (NUM_W+1)'(ca) - (NUM_W+1)'(oa) + HALF_N;
            den_neg = da[COORD_W-1];
         end else begin
            num     = (NUM_W+1)'(oa) - (NUM_W+1)'(ca) + HALF_N;
            den_neg = (da != '0) && !da[COORD_W-1];
         end
         nabs = num[NUM_W] ? NUM_W'(-num) : NUM_W'(num);
         dabs = da[COORD_W-1] ? DIV_W'(-da) : DIV_W'(da);
         nsh  = CMP_W'({nabs, {FRAC_BITS{1'b0}}});
         // quotient of 2^31 or more can never beat the limit
         ovf  = nsh >= (CMP_W'(dabs) << DIST_W);
         cnd  = (da != '0) && (num != '0) && (num[NUM_W] == den_neg) && !ovf;
         data_in.cand[i]     = cnd;
         data_in.rem[i]      = {nabs, {FRAC_BITS{1'b0}}};
         data_in.quo[i]      = '0;
         data_in.dvs[i / 2]  = dabs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

### rtl/rcfp_div_cell.sv
`default_nettype none
module rcfp_div_cell #(
   parameter int BIT = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire logic              in_valid,
   input  wire rcfp_pkg::div_type in_data,
   output logic                   valid_ff,
   output rcfp_pkg::div_type      data_ff
);
   import rcfp_pkg::*;

   div_type data_in;

   // settle quotient bit BIT of all six divisions
   always_comb begin
      logic [CMP_W-1:0] td;
      data_in = in_data;
      for (int i = 0; i < NUM_FACES; i++) begin
         td = CMP_W'(in_data.dvs[i / 2]) << BIT;
         if (CMP_W'(in_data.rem[i]) >= td) begin
            data_in.rem[i]      = in_data.rem[i] - REM_W'(td);
            data_in.quo[i][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

### rtl/rcfp_pick.sv
`default_nettype none
module rcfp_pick (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire rcfp_pkg::div_type             in_data,
   input  wire logic [rcfp_pkg::DIST_W-1:0]   max_len,
   output logic                               in_ready,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output rcfp_pkg::rsp_type                  rsp_data
);
   import rcfp_pkg::*;

   localparam logic signed [OFF_W-1:0] HALF_O = OFF_W'(1) <<< (FRAC_BITS - 1);
   localparam logic [COORD_W-1:0]      ONE_C  = COORD_W'(1) << FRAC_BITS;

   mul_type m_in, m_ff;
   logic    m_valid_ff, m_load, out_load;
   rsp_type rsp_in, rsp_ff;
   logic    rsp_valid_ff;

   assign out_load = !rsp_valid_ff || rsp_ready;
   assign m_load   = !m_valid_ff || out_load;
   assign in_ready = m_load;

   always_comb begin
      logic [1:0] bx;
      m_in     = '0;
      m_in.ray = in_data.ray;
      for (int i = 0; i < NUM_FACES; i++) begin
         m_in.t[i]  = in_data.quo[i];
         m_in.ok[i] = in_data.cand[i] && (in_data.quo[i] != '0) &&
                      (in_data.quo[i] < max_len);
         for (int k = 1; k < NUM_AXES; k++) begin
            bx = 2'((i / 2 + k) % NUM_AXES);
            m_in.prod[i][k-1] = PROD_W'($signed({1'b0, in_data.quo[i]}) *
               pick3(in_data.ray.dir_x, in_data.ray.dir_y, in_data.ray.dir_z, bx));
         end
      end
   end

   always_comb begin
      logic signed [PROD_W-1:0]  p;
      logic signed [OFF_W-1:0]   off;
      logic signed [COORD_W-1:0] ob, cb;
      logic [1:0]                bx;
      logic                      in_sq, hit;
      logic [FACE_W-1:0]         face;
      logic [DIST_W-1:0]         best;
      hit  = 1'b0;
      face = '0;
      best = '0;
      for (int i = 0; i < NUM_FACES; i++) begin
         in_sq = m_ff.ok[i];
         for (int k = 1; k < NUM_AXES; k++) begin
            bx  = 2'((i / 2 + k) % NUM_AXES);
            ob  = pick3(m_ff.ray.origin_x, m_ff.ray.origin_y, m_ff.ray.origin_z, bx);
            cb  = pick3(m_ff.ray.centre_x, m_ff.ray.centre_y, m_ff.ray.centre_z, bx);
            p   = $signed(m_ff.prod[i][k-1]);
            off = OFF_W'(ob) - OFF_W'(cb) + OFF_W'(p >>> FRAC_BITS);
            if (!((off > -HALF_O) && (off < HALF_O))) begin
               in_sq = 1'b0;
            end
         end
         // strict compare keeps the lowest face on a tie
         if (in_sq && (!hit || (m_ff.t[i] < best))) begin
            hit  = 1'b1;
            face = FACE_W'(i);
            best = m_ff.t[i];
         end
      end
      rsp_in = '0;
      if (hit) begin
         rsp_in.hit         = 1'b1;
         rsp_in.face        = face;
         rsp_in.distance    = best;
         rsp_in.neighbour_x = m_ff.ray.centre_x;
         rsp_in.neighbour_y = m_ff.ray.centre_y;
         rsp_in.neighbour_z = m_ff.ray.centre_z;
         unique case (face)
            3'd0:    rsp_in.neighbour_x = m_ff.ray.centre_x + ONE_C;
            3'd1:    rsp_in.neighbour_x = m_ff.ray.centre_x - ONE_C;
            3'd2:    rsp_in.neighbour_y = m_ff.ray.centre_y + ONE_C;
            3'd3:    rsp_in.neighbour_y = m_ff.ray.centre_y - ONE_C;
            3'd4:    rsp_in.neighbour_z = m_ff.ray.centre_z + ONE_C;
            default: rsp_in.neighbour_z = m_ff.ray.centre_z - ONE_C;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (m_load) begin
            m_valid_ff <= in_valid;
         end
         if (out_load) begin
            rsp_valid_ff <= m_valid_ff;
         end
      end
      if (m_load) begin
         m_ff <= m_in;
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

### verif/tb_ray_cube_face_pick_unit.sv
`timescale 1ns / 1ps
module tb_ray_cube_face_pick_unit;
   import rcfp_pkg::*;

   localparam int HALF_Q = 1 <<< (FRAC_BITS - 1);
   localparam int ONE_Q  = 1 <<< FRAC_BITS;
   localparam int PIPE_DEPTH  = 34;
   localparam int DRAIN_WAIT  = PIPE_DEPTH + 8;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_LEN = CSR_ADDR_W'(4 * REG_MAX_LEN);
   // the next register slot does not exist; writes there must be dropped
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED = CSR_ADDR_W'(4);
   localparam int RANDOM_ITEMS = 1450;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   ray_cube_face_pick_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of the single register
   logic [DIST_W-1:0] ray_limit = MAX_LEN_RESET;
   rsp_type pending_picks[$];
   int mismatches = 0;
   int rays_sent = 0;
   int picks_seen = 0;
   int hits_seen = 0;
   int face_count[NUM_FACES];
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   bit hold_request = 1'b0;
   int stall_cycles = 0;

   // Walk the six faces in order; a strictly smaller t wins, so the lower
   // face index keeps a tie.
   function automatic rsp_type pick_face(req_type r, logic [DIST_W-1:0] lim);
      longint o[3], d[3], c[3];
      longint num, den, t, off, best, s;
      int a, b;
      bit in_sq, hit;
      int face;
      rsp_type y;
      o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
      d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
      c[0] = r.centre_x; c[1] = r.centre_y; c[2] = r.centre_z;
      best = lim;
      hit = 1'b0;
      face = 0;
      for (int i = 0; i < NUM_FACES; i++) begin
         a = i / 2;
         s = (i % 2) ? -1 : 1;
         num = s * (c[a] + s * HALF_Q - o[a]);
         den = s * d[a];
         if (den == 0 || num == 0 || ((num < 0) != (den < 0))) continue;
         t = ((num < 0 ? -num : num) <<< FRAC_BITS) / (den < 0 ? -den : den);
         if (t == 0 || t >= best) continue;
         in_sq = 1'b1;
         for (int k = 1; k < 3; k++) begin
            b = (a + k) % 3;
            // arithmetic shift floors toward minus infinity
            off = o[b] - c[b] + ((t * d[b]) >>> FRAC_BITS);
            if ((off < 0 ? -off : off) >= HALF_Q) in_sq = 1'b0;
         end
         if (!in_sq) continue;
         best = t;
         face = i;
         hit = 1'b1;
      end
      y = '0;
      if (hit) begin
         y.hit = 1'b1;
         y.face = FACE_W'(face);
         y.neighbour_x = COORD_W'(c[0] + ((face / 2 == 0) ? ((face % 2) ? -ONE_Q : ONE_Q) : 0));
         y.neighbour_y = COORD_W'(c[1] + ((face / 2 == 1) ? ((face % 2) ? -ONE_Q : ONE_Q) : 0));
         y.neighbour_z = COORD_W'(c[2] + ((face / 2 == 2) ? ((face % 2) ? -ONE_Q : ONE_Q) : 0));
         y.distance = DIST_W'(best);
      end
      return y;
   endfunction

   // Monitor: predict on input accept, check on output accept.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_picks.push_back(pick_face(req_data, ray_limit));
            rays_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            picks_seen++;
            if (pending_picks.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected pick result %p", rsp_data);
            end else begin
               want = pending_picks.pop_front();
               if (rsp_data.hit !== want.hit || rsp_data.face !== want.face ||
                   rsp_data.neighbour_x !== want.neighbour_x ||
                   rsp_data.neighbour_y !== want.neighbour_y ||
                   rsp_data.neighbour_z !== want.neighbour_z ||
                   rsp_data.distance !== want.distance) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("pick mismatch: expected %p got %p", want, rsp_data);
               end
               if (want.hit) begin
                  hits_seen++;
                  face_count[want.face]++;
               end
            end
         end
      end
   end

   // Watchdog: count cycles where neither channel moves an item.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("ray_cube_face_pick_unit verification failed");
         $finish;
      end
   end

   // Receiver: random back-pressure, plus one long hold-off on request.
   initial begin
      int held;
      held = 0;
      forever begin
         @(negedge clock);
         if (hold_request && held == 0) held = HOLD_CYCLES;
         if (held > 0) begin
            rsp_ready <= 1'b0;
            held--;
            if (held == 0) hold_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // Offer one ray; hold valid and payload until accepted.
   task automatic send_ray(input req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid, wait for every pick, then let the pipeline empty.
   task automatic drain_picks();
      req_valid <= 1'b0;
      while (pending_picks.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_MAX_LEN) ray_limit = value[DIST_W-1:0];
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   function automatic logic signed [31:0] near_q(input int span);
      return $signed($urandom_range(2 * span)) - span;
   endfunction

   // Mostly rays aimed near the cube from a few cells away; the rest noise.
   function automatic req_type make_ray();
      req_type r;
      int roll;
      roll = $urandom_range(99);
      if (roll < 25) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
         return r;
      end
      r.centre_x = near_q(1 << 22);
      r.centre_y = near_q(1 << 22);
      r.centre_z = near_q(1 << 22);
      if (roll < 35) begin
         // origin inside the cube: exits through one face
         r.origin_x = r.centre_x + near_q(HALF_Q - 1);
         r.origin_y = r.centre_y + near_q(HALF_Q - 1);
         r.origin_z = r.centre_z + near_q(HALF_Q - 1);
      end else begin
         r.origin_x = r.centre_x + near_q(6 * ONE_Q);
         r.origin_y = r.centre_y + near_q(6 * ONE_Q);
         r.origin_z = r.centre_z + near_q(6 * ONE_Q);
      end
      r.dir_x = (r.centre_x + near_q(40000) - r.origin_x) >>> $urandom_range(3);
      r.dir_y = (r.centre_y + near_q(40000) - r.origin_y) >>> $urandom_range(3);
      r.dir_z = (r.centre_z + near_q(40000) - r.origin_z) >>> $urandom_range(3);
      if ($urandom_range(9) == 0) r.dir_x = '0;
      if ($urandom_range(9) == 0) r.dir_y = '0;
      if ($urandom_range(9) == 0) r.dir_z = '0;
      if ($urandom_range(19) == 0) r.dir_z = -r.dir_z;
      return r;
   endfunction

   typedef struct {
      req_type ray;
      bit      typed;
      rsp_type want;
   } ray_row_type;

   ray_row_type ray_rows[$];

   initial begin
      ray_row_type row;
      int lim_choice[3];
      int idle_tx[3];
      int idle_rx[3];
      for (int i = 0; i < NUM_FACES; i++) face_count[i] = 0;

      // straight up +z onto the cube at z=3: enters the -z face at t=2.5
      row.ray = '0; row.ray.dir_z = ONE_Q; row.ray.centre_z = 3 * ONE_Q;
      row.typed = 1'b1; row.want = '0;
      row.want.hit = 1'b1; row.want.face = 3'd5; row.want.neighbour_z = 2 * ONE_Q;
      row.want.distance = 31'd163840;
      ray_rows.push_back(row);
      // zero direction: every face skipped
      row.ray = '0; row.ray.centre_x = ONE_Q; row.typed = 1'b1; row.want = '0;
      ray_rows.push_back(row);
      // all fields at the negative extreme, then the positive one, then all ones
      row.typed = 1'b0;
      row.ray = {9{32'h8000_0000}}; ray_rows.push_back(row);
      row.ray = {9{32'h7fff_ffff}}; ray_rows.push_back(row);
      row.ray = {9{32'hffff_ffff}}; ray_rows.push_back(row);
      // approach along each face normal from three cells out
      for (int f = 0; f < NUM_FACES; f++) begin
         row.ray = '0;
         case (f)
            0: begin row.ray.origin_x =  3 * ONE_Q; row.ray.dir_x = -ONE_Q; end
            1: begin row.ray.origin_x = -3 * ONE_Q; row.ray.dir_x =  ONE_Q; end
            2: begin row.ray.origin_y =  3 * ONE_Q; row.ray.dir_y = -ONE_Q; end
            3: begin row.ray.origin_y = -3 * ONE_Q; row.ray.dir_y =  ONE_Q; end
            4: begin row.ray.origin_z =  3 * ONE_Q; row.ray.dir_z = -ONE_Q; end
            default: begin row.ray.origin_z = -3 * ONE_Q; row.ray.dir_z = ONE_Q; end
         endcase
         ray_rows.push_back(row);
      end
      // start at the centre heading +x: leaves through +x at t=0.5
      row.ray = '0; row.ray.dir_x = ONE_Q; ray_rows.push_back(row);
      // t truncates to zero: plane one LSB away, huge direction
      row.ray = '0; row.ray.origin_x = -HALF_Q - 1; row.ray.dir_x = 32'h7fff_ffff;
      ray_rows.push_back(row);
      // diagonal through an edge: equal t on two faces, but the edge lies outside both open squares, so no hit
      row.ray = '0; row.ray.origin_x = 3 * ONE_Q; row.ray.origin_y = 3 * ONE_Q;
      row.ray.dir_x = -ONE_Q; row.ray.dir_y = -ONE_Q; ray_rows.push_back(row);
      // grazing just outside the face square
      row.ray = '0; row.ray.origin_x = 3 * ONE_Q; row.ray.origin_y = HALF_Q;
      row.ray.dir_x = -ONE_Q; ray_rows.push_back(row);
      // beyond the default limit of 1000.0
      row.ray = '0; row.ray.origin_x = 32'h0400_0000; row.ray.dir_x = -ONE_Q;
      ray_rows.push_back(row);

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows at the reset limit, no idling
      foreach (ray_rows[i]) begin
         if (ray_rows[i].typed && pick_face(ray_rows[i].ray, ray_limit) != ray_rows[i].want)
            $display("directed row %0d: typed result disagrees with prediction", i);
         send_ray(ray_rows[i].ray);
      end
      drain_picks();

      // zero limit: nothing can qualify; the unused slot must not disturb it
      csr_write(ADDR_MAX_LEN, 32'd0);
      csr_write(ADDR_UNUSED, 32'h7fff_ffff);
      foreach (ray_rows[i]) send_ray(ray_rows[i].ray);
      drain_picks();

      lim_choice[0] = 32'h7fff_ffff;
      lim_choice[1] = 4 * ONE_Q;
      lim_choice[2] = int'(MAX_LEN_RESET);
      idle_tx[0] = 14; idle_rx[0] = 82;
      idle_tx[1] = 82; idle_rx[1] = 14;
      idle_tx[2] = 0;  idle_rx[2] = 0;
      for (int p = 0; p < 3; p++) begin
         csr_write(ADDR_MAX_LEN, lim_choice[p]);
         sender_idle_pct = idle_tx[p];
         receiver_idle_pct = idle_rx[p];
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            // fill the pipeline behind a long receiver stall once
            if (p == 2 && n == 100) hold_request = 1'b1;
            // one mid-phase pause until every pick has come back
            if (n == RANDOM_ITEMS / 6) drain_picks();
            send_ray(make_ray());
         end
         drain_picks();
      end

      $display("rays %0d, picks %0d, hits %0d (faces %0d/%0d/%0d/%0d/%0d/%0d)",
               rays_sent, picks_seen, hits_seen, face_count[0], face_count[1],
               face_count[2], face_count[3], face_count[4], face_count[5]);
      $display("limits: reset, zero, max, 4.0; three idling mixes and a long stall");
      if (mismatches == 0 && pending_picks.size() == 0) begin
         $display("ray_cube_face_pick_unit verification clean");
      end else begin
         $display("mismatches %0d, picks still owed %0d", mismatches, pending_picks.size());
         $display("ray_cube_face_pick_unit verification failed");
      end
      $finish;
   end

endmodule
